// ===== hdl/windowed_fourier_value_and_gradient_core_assert.svh =====
// Assertion macros used by the checker of the windowed Fourier core.
`ifndef WINDOWED_FOURIER_VALUE_AND_GRADIENT_CORE_ASSERT_SVH
`define WINDOWED_FOURIER_VALUE_AND_GRADIENT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WFVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wfvg_pkg.sv =====
// Shared constants, types and tables of the windowed Fourier core.
`timescale 1ns / 1ps
`default_nettype none
package wfvg_pkg;

  localparam int unsigned SINCOS_STAGES = 24;
  localparam int unsigned CORDIC_LAT    = SINCOS_STAGES + 2;
  localparam int unsigned WIN_LAT       = 6;
  localparam int unsigned DLY_LEN       = CORDIC_LAT + 1 - WIN_LAT;
  localparam int unsigned PIPE_LEN      = CORDIC_LAT + 6;

  localparam int unsigned COORD_W     = 26;
  localparam int unsigned FREQ_W      = 24;
  localparam int unsigned VAL_W       = 24;
  localparam int unsigned GRAD_W      = 40;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 208;
  localparam int unsigned W_W         = 25;
  localparam int unsigned D_W         = 26;
  localparam int unsigned A_W         = 37;
  localparam int unsigned CS_W        = 24;
  localparam int unsigned CX_W        = 34;
  localparam int unsigned CZ_W        = 33;

  localparam logic signed [26:0] ONE_S    = 27'sd16777216;
  localparam logic signed [26:0] HALF_S   = 27'sd8388608;
  localparam logic signed [26:0] RAMP_S   = 27'sd1677722;
  localparam logic [W_W-1:0]     ONE_W    = 25'd16777216;
  localparam logic [16:0]        TWO_PI_HI = 17'd102943;
  localparam logic [17:0]        TWO_PI_LO = 18'd185617;
  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic [W_W-1:0]        w;
    logic signed [D_W-1:0] d;
    logic signed [A_W-1:0] a;
  } win_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [29:0] cordic_angle(input int unsigned idx);
    logic [29:0] r;
    case (idx)
      0: r = 30'd536870912;
      1: r = 30'd316933406;
      2: r = 30'd167458907;
      3: r = 30'd85004756;
      4: r = 30'd42667331;
      5: r = 30'd21354465;
      6: r = 30'd10679838;
      7: r = 30'd5340245;
      8: r = 30'd2670163;
      9: r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      24: r = 30'd41;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      28: r = 30'd3;
      29: r = 30'd1;
      30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [25:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -26'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [41:0] v);
    logic signed [GRAD_W-1:0] r;
    if (v > 42'sd549755813887) begin
      r = 40'sd549755813887;
    end else if (v < -42'sd549755813888) begin
      r = -40'sd549755813888;
    end else begin
      r = v[GRAD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/wfvg_window.sv =====
// Six-stage pipeline for the cut-off window, its slope and the scaled frequency term.
`timescale 1ns / 1ps
`default_nettype none
module wfvg_window (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [wfvg_pkg::COORD_W-1:0] s_i,
  input  wire logic signed [wfvg_pkg::FREQ_W-1:0]  f_i,
  output wfvg_pkg::win_t                           res_o
);

  // Stage 1: mirror, range flags, t = 10 s, partial products of 2 pi f.
  logic signed [26:0] s_ext, sm;
  logic               mir_c, zero_c, one_c;
  logic [24:0]        t10;
  logic [23:0]        t_c, u_c;
  logic signed [41:0] ph_c, pl_c;

  logic               mir1_q, zero1_q, one1_q;
  logic [23:0]        t1_q, u1_q;
  logic signed [41:0] ph1_q, pl1_q;

  always_comb begin
    s_ext  = {s_i[wfvg_pkg::COORD_W-1], s_i};
    mir_c  = s_ext > wfvg_pkg::HALF_S;
    sm     = mir_c ? (wfvg_pkg::ONE_S - s_ext) : s_ext;
    zero_c = sm <= 27'sd0;
    one_c  = sm >= wfvg_pkg::RAMP_S;
    t10    = {4'd0, sm[20:0]} * 25'd10;
    t_c    = t10[23:0];
    u_c    = 24'(25'd16777216 - {1'b0, t_c});
    ph_c   = f_i * $signed({1'b0, wfvg_pkg::TWO_PI_HI});
    pl_c   = f_i * $signed({1'b0, wfvg_pkg::TWO_PI_LO});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mir1_q  <= mir_c;
      zero1_q <= zero_c;
      one1_q  <= one_c;
      t1_q    <= t_c;
      u1_q    <= u_c;
      ph1_q   <= ph_c;
      pl1_q   <= pl_c;
    end
  end

  // Stage 2: squares of t and 1-t, rounded angular frequency.
  logic [47:0]        tt_c, uu_c;
  logic signed [59:0] omf_c;
  logic signed [35:0] om_c;

  logic               mir2_q, zero2_q, one2_q;
  logic [23:0]        t2_q, tsq2_q, usq2_q;
  logic signed [35:0] om2_q;

  always_comb begin
    tt_c  = t1_q * t1_q;
    uu_c  = u1_q * u1_q;
    omf_c = (60'(ph1_q) <<< 18) + 60'(pl1_q);
    om_c  = 36'((omf_c + 60'sd8388608) >>> 24);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mir2_q  <= mir1_q;
      zero2_q <= zero1_q;
      one2_q  <= one1_q;
      t2_q    <= t1_q;
      tsq2_q  <= 24'((tt_c + 48'd8388608) >> 24);
      usq2_q  <= 24'((uu_c + 48'd8388608) >> 24);
      om2_q   <= om_c;
    end
  end

  // Stage 3: t^3, t^2 (1-t)^2 and the polynomial 6t^2 - 15t + 10.
  logic [47:0]        t3p_c, qp_c;
  logic [29:0]        p_c;

  logic               mir3_q, zero3_q, one3_q;
  logic [23:0]        t3_q, q3_q;
  logic [29:0]        p3_q;
  logic signed [35:0] om3_q;

  always_comb begin
    t3p_c = tsq2_q * t2_q;
    qp_c  = tsq2_q * usq2_q;
    p_c   = 30'(tsq2_q) * 30'd6 + 30'd167772160 - 30'(t2_q) * 30'd15;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mir3_q  <= mir2_q;
      zero3_q <= zero2_q;
      one3_q  <= one2_q;
      t3_q    <= 24'((t3p_c + 48'd8388608) >> 24);
      q3_q    <= 24'((qp_c + 48'd8388608) >> 24);
      p3_q    <= p_c;
      om3_q   <= om2_q;
    end
  end

  // Stage 4: smootherstep value with clamp, and the slope 300 q with its sign.
  logic [53:0]            cp_c;
  logic [30:0]            c_full;
  logic [wfvg_pkg::W_W-1:0] w_c;
  logic [32:0]            dpos_c;
  logic signed [33:0]     dws_c;
  logic signed [wfvg_pkg::D_W-1:0] d_c;

  logic [wfvg_pkg::W_W-1:0]        w4_q;
  logic signed [wfvg_pkg::D_W-1:0] d4_q;
  logic signed [35:0]              om4_q;

  always_comb begin
    cp_c   = t3_q * p3_q;
    c_full = 31'((cp_c + 54'd8388608) >> 24);
    if (zero3_q) begin
      w_c = '0;
    end else if (one3_q || (c_full > 31'd16777216)) begin
      w_c = wfvg_pkg::ONE_W;
    end else begin
      w_c = c_full[wfvg_pkg::W_W-1:0];
    end
    dpos_c = 33'(q3_q) * 33'd300;
    dws_c  = mir3_q ? -$signed({1'b0, dpos_c}) : $signed({1'b0, dpos_c});
    if (zero3_q || one3_q) begin
      d_c = '0;
    end else begin
      d_c = 26'((dws_c + 34'sd128) >>> 8);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w4_q  <= w_c;
      d4_q  <= d_c;
      om4_q <= om3_q;
    end
  end

  // Stage 5: 2 pi f times W, split in two partial products.
  logic signed [17:0] omh_c;
  logic [17:0]        oml_c;

  logic signed [43:0]              ah5_q;
  logic [42:0]                     al5_q;
  logic [wfvg_pkg::W_W-1:0]        w5_q;
  logic signed [wfvg_pkg::D_W-1:0] d5_q;

  always_comb begin
    omh_c = om4_q[35:18];
    oml_c = om4_q[17:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ah5_q <= omh_c * $signed({1'b0, w4_q});
      al5_q <= oml_c * w4_q;
      w5_q  <= w4_q;
      d5_q  <= d4_q;
    end
  end

  // Stage 6: combine and round the scaled frequency term.
  logic signed [61:0] af_c;
  wfvg_pkg::win_t     res_q;

  always_comb begin
    af_c = (62'(ah5_q) <<< 18) + $signed({19'd0, al5_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.w <= w5_q;
      res_q.d <= d5_q;
      res_q.a <= 37'((af_c + 62'sd8388608) >>> 24);
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== hdl/wfvg_cordic.sv =====
// Pipelined rotation CORDIC giving cosine and sine of a phase in turns.
`timescale 1ns / 1ps
`default_nettype none
module wfvg_cordic (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic [31:0]                      turns_i,
  output logic signed [wfvg_pkg::CS_W-1:0]      cos_o,
  output logic signed [wfvg_pkg::CS_W-1:0]      sin_o
);

  localparam int unsigned N = wfvg_pkg::SINCOS_STAGES;

  logic signed [wfvg_pkg::CX_W-1:0] x_q [0:N];
  logic signed [wfvg_pkg::CX_W-1:0] y_q [0:N];
  logic signed [wfvg_pkg::CZ_W-1:0] z_q [0:N];
  logic                             flip_q [0:N];

  // Fold the phase into the right half plane; a half-turn move negates both results.
  logic signed [wfvg_pkg::CZ_W-1:0] z_in, z_fold;
  logic                             flip_c;

  always_comb begin
    z_in = $signed({turns_i[31], turns_i});
    if (z_in > 33'sd1073741824) begin
      z_fold = z_in - 33'sd2147483648;
      flip_c = 1'b1;
    end else if (z_in < -33'sd1073741824) begin
      z_fold = z_in + 33'sd2147483648;
      flip_c = 1'b1;
    end else begin
      z_fold = z_in;
      flip_c = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= wfvg_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      flip_q[0] <= flip_c;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [wfvg_pkg::CZ_W-1:0] ang;
    assign ang = $signed({3'd0, wfvg_pkg::cordic_angle(i)});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ang;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ang;
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  logic signed [wfvg_pkg::CX_W-1:0] xf, yf;
  logic signed [wfvg_pkg::CS_W-1:0] cos_q, sin_q;

  always_comb begin
    xf = flip_q[N] ? -x_q[N] : x_q[N];
    yf = flip_q[N] ? -y_q[N] : y_q[N];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= 24'((xf + 34'sd128) >>> 8);
      sin_q <= 24'((yf + 34'sd128) >>> 8);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule
`default_nettype wire

// ===== hdl/windowed_fourier_value_and_gradient_core.sv =====
// Windowed Fourier sample and its two complex partial derivatives, fully pipelined.
//
// Input words arrive on s_axis (tdata: coord_one, coord_two, freq_one, freq_two from
// the low bits up). Each accepted word gives exactly one result word on m_axis
// (tdata: value_re, value_im, grad_one_re, grad_one_im, grad_two_re, grad_two_im).
// The block takes one word per cycle while the output is not stalled. From input
// to output a word passes two phase stages, the CORDIC pipeline with its fold and
// rounding stages, and four stages that form the products. The window pipelines
// run beside the CORDIC and their results wait in a delay line until the sine and
// cosine are ready.
// A stall holds every stage: s_axis_tready is low only while a result sits in
// the output register and m_axis_tready is low, so no word is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready right after it.
`timescale 1ns / 1ps
`default_nettype none
module windowed_fourier_value_and_gradient_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // coord_one[25:0], coord_two[51:26], freq_one[75:52], freq_two[99:76], zero fill
  input  wire logic [wfvg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // value_re[23:0], value_im[47:24], grad_one_re[87:48], grad_one_im[127:88],
  // grad_two_re[167:128], grad_two_im[207:168]
  output logic [wfvg_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  typedef struct packed {
    wfvg_pkg::win_t one;
    wfvg_pkg::win_t two;
  } wpair_t;

  localparam int unsigned P = wfvg_pkg::PIPE_LEN;

  logic [P-1:0] vld_q;
  logic         adv;

  assign adv           = !vld_q[P-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[P-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[P-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: register the fields and the low words of the phase products.
  logic signed [wfvg_pkg::COORD_W-1:0] x1_in, x2_in;
  logic signed [wfvg_pkg::FREQ_W-1:0]  f1_in, f2_in;
  logic signed [49:0]                  p1_c, p2_c;

  logic signed [wfvg_pkg::COORD_W-1:0] x1_q, x2_q;
  logic signed [wfvg_pkg::FREQ_W-1:0]  f1_q, f2_q;
  logic [31:0]                         p1_q, p2_q, turns_q;

  always_comb begin
    x1_in = s_axis_tdata[25:0];
    x2_in = s_axis_tdata[51:26];
    f1_in = s_axis_tdata[75:52];
    f2_in = s_axis_tdata[99:76];
    p1_c  = x1_in * f1_in;
    p2_c  = x2_in * f2_in;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q <= x1_in;
      x2_q <= x2_in;
      f1_q <= f1_in;
      f2_q <= f2_in;
      p1_q <= p1_c[31:0];
      p2_q <= p2_c[31:0];
      // Stage 1: the phase is the negated sum, wrapping mod one turn.
      turns_q <= 32'd0 - (p1_q + p2_q);
    end
  end

  wfvg_pkg::win_t win1, win2;

  wfvg_window u_win_one (
    .clk_i (clk_i),
    .en_i  (adv),
    .s_i   (x1_q),
    .f_i   (f1_q),
    .res_o (win1)
  );

  wfvg_window u_win_two (
    .clk_i (clk_i),
    .en_i  (adv),
    .s_i   (x2_q),
    .f_i   (f2_q),
    .res_o (win2)
  );

  logic signed [wfvg_pkg::CS_W-1:0] cs, sn;

  wfvg_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (adv),
    .turns_i (turns_q),
    .cos_o   (cs),
    .sin_o   (sn)
  );

  // Window results wait here until the CORDIC output lines up.
  wpair_t dly_q [0:wfvg_pkg::DLY_LEN-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly_q[0] <= '{one: win1, two: win2};
      for (int k = 1; k < wfvg_pkg::DLY_LEN; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  wpair_t wp;
  assign wp = dly_q[wfvg_pkg::DLY_LEN-1];

  // Q1: slope and frequency terms times cosine and sine; product of windows.
  logic [49:0]                      wwp_c;
  logic signed [49:0]               dc1_q, ds1_q, dc2_q, ds2_q;
  logic signed [60:0]               as1_q, ac1_q, as2_q, ac2_q;
  logic [wfvg_pkg::W_W-1:0]         ww1_q, wa1_q, wb1_q;
  logic signed [wfvg_pkg::CS_W-1:0] cs1_q, sn1_q;

  assign wwp_c = wp.one.w * wp.two.w;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dc1_q <= wp.one.d * cs;
      ds1_q <= wp.one.d * sn;
      as1_q <= wp.one.a * sn;
      ac1_q <= wp.one.a * cs;
      dc2_q <= wp.two.d * cs;
      ds2_q <= wp.two.d * sn;
      as2_q <= wp.two.a * sn;
      ac2_q <= wp.two.a * cs;
      ww1_q <= 25'((wwp_c + 50'd8388608) >> 24);
      wa1_q <= wp.one.w;
      wb1_q <= wp.two.w;
      cs1_q <= cs;
      sn1_q <= sn;
    end
  end

  // Q2: inner gradient terms rounded to Q.16; value products.
  logic signed [61:0] s1r_c, s1i_c, s2r_c, s2i_c;
  logic signed [39:0] ir1_q, ii1_q, ir2_q, ii2_q;
  logic signed [49:0] vc2_q, vs2_q;
  logic [wfvg_pkg::W_W-1:0] wa2_q, wb2_q;

  always_comb begin
    s1r_c = 62'(dc1_q) + 62'(as1_q);
    s1i_c = 62'(ds1_q) - 62'(ac1_q);
    s2r_c = 62'(dc2_q) + 62'(as2_q);
    s2i_c = 62'(ds2_q) - 62'(ac2_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ir1_q <= 40'((s1r_c + 62'sd2097152) >>> 22);
      ii1_q <= 40'((s1i_c + 62'sd2097152) >>> 22);
      ir2_q <= 40'((s2r_c + 62'sd2097152) >>> 22);
      ii2_q <= 40'((s2i_c + 62'sd2097152) >>> 22);
      vc2_q <= cs1_q * $signed({1'b0, ww1_q});
      vs2_q <= sn1_q * $signed({1'b0, ww1_q});
      wa2_q <= wa1_q;
      wb2_q <= wb1_q;
    end
  end

  // Q3: weight each gradient by the other coordinate's window; finish the value.
  logic signed [65:0] g1r3_q, g1i3_q, g2r3_q, g2i3_q;
  logic signed [wfvg_pkg::VAL_W-1:0] vre3_q, vim3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1r3_q <= ir1_q * $signed({1'b0, wb2_q});
      g1i3_q <= ii1_q * $signed({1'b0, wb2_q});
      g2r3_q <= ir2_q * $signed({1'b0, wa2_q});
      g2i3_q <= ii2_q * $signed({1'b0, wa2_q});
      vre3_q <= wfvg_pkg::sat_val(26'((vc2_q + 50'sd8388608) >>> 24));
      vim3_q <= wfvg_pkg::sat_val(26'((vs2_q + 50'sd8388608) >>> 24));
    end
  end

  // Q4: round and saturate the gradients into the output register.
  logic signed [wfvg_pkg::GRAD_W-1:0] g1r_q, g1i_q, g2r_q, g2i_q;
  logic signed [wfvg_pkg::VAL_W-1:0]  vre_q, vim_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1r_q <= wfvg_pkg::sat_grad(42'((g1r3_q + 66'sd8388608) >>> 24));
      g1i_q <= wfvg_pkg::sat_grad(42'((g1i3_q + 66'sd8388608) >>> 24));
      g2r_q <= wfvg_pkg::sat_grad(42'((g2r3_q + 66'sd8388608) >>> 24));
      g2i_q <= wfvg_pkg::sat_grad(42'((g2i3_q + 66'sd8388608) >>> 24));
      vre_q <= vre3_q;
      vim_q <= vim3_q;
    end
  end

  assign m_axis_tdata = {g2i_q, g2r_q, g1i_q, g1r_q, vim_q, vre_q};

endmodule
`default_nettype wire

// ===== hdl/wfvg_checker.sv =====
// Port-level checks of the windowed Fourier core and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_fourier_value_and_gradient_core_assert.svh"
module wfvg_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 s_axis_tready,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [wfvg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  // A result word that is not taken stays in place unchanged.
  `WFVG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

  // With the output register empty the pipeline must take input.
  `WFVG_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // A ready receiver never causes back-pressure on the input side.
  `WFVG_ASSERT_NOW(a_ready_passes, m_axis_tready, s_axis_tready, "input stalled while receiver ready")

endmodule

bind windowed_fourier_value_and_gradient_core wfvg_checker u_wfvg_checker (.*);
`default_nettype wire

// ===== dv/tb_windowed_fourier_value_and_gradient_core.sv =====
// Self-checking testbench of the windowed Fourier value and gradient core.
`timescale 1ns / 1ps
module tb_windowed_fourier_value_and_gradient_core;

  localparam longint unsigned GAIN_Q30  = 64'd652032874;
  localparam longint          TWO_PI_Q32 = 64'sd26986075409;
  localparam longint          RAMP_END  = 64'sd1677722;
  localparam longint          ONE_Q24   = 64'sd16777216;
  localparam longint          HALF_Q24  = 64'sd8388608;
  localparam int              LATENCY   = wfvg_pkg::SINCOS_STAGES + 8;

  typedef struct packed {
    logic signed [wfvg_pkg::GRAD_W-1:0] g2i;
    logic signed [wfvg_pkg::GRAD_W-1:0] g2r;
    logic signed [wfvg_pkg::GRAD_W-1:0] g1i;
    logic signed [wfvg_pkg::GRAD_W-1:0] g1r;
    logic signed [wfvg_pkg::VAL_W-1:0]  vim;
    logic signed [wfvg_pkg::VAL_W-1:0]  vre;
  } sample_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [wfvg_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [wfvg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  sample_t expected_samples[$];
  int      n_errors;
  bit      hold_off_req;

  windowed_fourier_value_and_gradient_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  // Rounding shift right: adds half an LSB, then >>> on a signed longint floors.
  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -(64'sd1 <<< (w - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void cutoff_window(input longint s_in, output longint w,
                                        output longint dw);
    longint s, t, u, t2, t3, u2, p, c, q;
    bit mirrored;
    s = s_in;
    mirrored = 1'b0;
    if (s > HALF_Q24) begin
      s = ONE_Q24 - s;
      mirrored = 1'b1;
    end
    w = 0;
    dw = 0;
    if (s >= RAMP_END) begin
      w = ONE_Q24;
    end else if (s > 0) begin
      t  = 10 * s;
      u  = ONE_Q24 - t;
      t2 = round_shift(t * t, 24);
      t3 = round_shift(t2 * t, 24);
      p  = 6 * t2 - 15 * t + 10 * ONE_Q24;
      c  = round_shift(t3 * p, 24);
      if (c > ONE_Q24) c = ONE_Q24;
      if (c < 0) c = 0;
      u2 = round_shift(u * u, 24);
      q  = round_shift(t2 * u2, 24);
      w  = c;
      dw = mirrored ? -300 * q : 300 * q;
    end
  endfunction

  function automatic void cordic_sincos(input logic [31:0] turns, output longint cs,
                                        output longint sn);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(turns));
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31;
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31;
      flip = 1'b1;
    end
    for (int i = 0; i < wfvg_pkg::SINCOS_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(wfvg_pkg::cordic_angle(i % 32));
      end else begin
        x += dx; y -= dy; z += longint'(wfvg_pkg::cordic_angle(i % 32));
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = round_shift(x, 8);
    sn = round_shift(y, 8);
  endfunction

  function automatic void partial_deriv(input longint fr, input longint w_own,
                                        input longint dw_own, input longint w_other,
                                        input longint cs, input longint sn,
                                        output longint re, output longint im);
    longint om, a, d, ir, ii;
    om = round_shift(fr * TWO_PI_Q32, 24);
    a  = round_shift(om * w_own, 24);
    d  = round_shift(dw_own, 8);
    ir = round_shift(d * cs + a * sn, 22);
    ii = round_shift(d * sn - a * cs, 22);
    re = clip(round_shift(ir * w_other, 24), 40);
    im = clip(round_shift(ii * w_other, 24), 40);
  endfunction

  function automatic sample_t predict_sample(logic [wfvg_pkg::IN_TDATA_W-1:0] word);
    longint x1, x2, f1, f2, acc, w1, dw1, w2, dw2, cs, sn, ww, r0, r1, r2, r3;
    logic [31:0] turns;
    sample_t s;
    x1 = longint'($signed(word[25:0]));
    x2 = longint'($signed(word[51:26]));
    f1 = longint'($signed(word[75:52]));
    f2 = longint'($signed(word[99:76]));
    acc = x1 * f1 + x2 * f2;
    turns = 32'(-acc);
    cutoff_window(x1, w1, dw1);
    cutoff_window(x2, w2, dw2);
    cordic_sincos(turns, cs, sn);
    ww = round_shift(w1 * w2, 24);
    s.vre = wfvg_pkg::VAL_W'(clip(round_shift(cs * ww, 24), 24));
    s.vim = wfvg_pkg::VAL_W'(clip(round_shift(sn * ww, 24), 24));
    partial_deriv(f1, w1, dw1, w2, cs, sn, r0, r1);
    partial_deriv(f2, w2, dw2, w1, cs, sn, r2, r3);
    s.g1r = wfvg_pkg::GRAD_W'(r0);
    s.g1i = wfvg_pkg::GRAD_W'(r1);
    s.g2r = wfvg_pkg::GRAD_W'(r2);
    s.g2i = wfvg_pkg::GRAD_W'(r3);
    return s;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(99) < 40) return 0;
    if ($urandom_range(99) < 90) return $urandom_range(3);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_word(input logic [25:0] x1, input logic [25:0] x2,
                           input logic [23:0] f1, input logic [23:0] f2, input bit gaps);
    logic [wfvg_pkg::IN_TDATA_W-1:0] word;
    int gap;
    word = {4'd0, f2, f1, x2, x1};
    gap = gaps ? random_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    expected_samples.push_back(predict_sample(word));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    go_idle();
    while (expected_samples.size() != 0) @(posedge clk_i);
  endtask

  // Random coordinate, mostly inside 0..1 with the ramps hit often.
  function automatic logic [25:0] rand_coord();
    int k;
    k = $urandom_range(9);
    if (k < 3) return 26'($urandom_range(1677800));
    if (k < 6) return 26'(ONE_Q24 - $urandom_range(1677800));
    if (k < 8) return 26'($urandom_range(16777216));
    return 26'($urandom);
  endfunction

  function automatic logic [23:0] rand_freq();
    if ($urandom_range(3) == 0) return 24'($urandom);
    return 24'($signed(11'($urandom)));
  endfunction

  task automatic test_directed();
    logic [25:0] coords[10];
    logic [23:0] freqs[5];
    coords = '{26'h2000000, 26'h1ffffff, 26'd0, 26'd1, 26'd1677721, 26'd1677722,
               26'd8388608, 26'd8388609, 26'd16777216, 26'h3ffffff};
    freqs = '{24'h800000, 24'h7fffff, 24'd0, 24'hffffff, 24'd256};
    for (int i = 0; i < 10; i++)
      send_word(coords[i], coords[9 - i], freqs[i % 5], freqs[(i + 2) % 5], 1'b0);
    for (int i = 0; i < 10; i++)
      send_word(coords[i], 26'd8388608, freqs[(i + 3) % 5], freqs[i % 5], 1'b1);
    send_word(26'd800000, 26'd900000, 24'h7fffff, 24'h800000, 1'b0);
    send_word(26'd15900000, 26'd16000000, 24'h800000, 24'h7fffff, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_word(rand_coord(), rand_coord(), rand_freq(), rand_freq(), 1'b1);
    wait_drained();
  endtask

  // Receiver stops for a long stretch while words keep coming.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 80; i++)
      send_word(rand_coord(), rand_coord(), rand_freq(), rand_freq(), 1'b0);
    wait_drained();
  endtask

  // Receiver: random stalls, and a long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
      end else if ($urandom_range(99) < 25) begin
        m_axis_tready <= 1'b0;
        repeat (random_gap() + 1) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    sample_t got, exp_s;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_samples.size() == 0) begin
        $display("%0t: result word with no prediction: %h", $time, got);
        n_errors++;
      end else begin
        exp_s = expected_samples.pop_front();
        if (got.vre != exp_s.vre)
          $display("%0t: value_re expected %0d actual %0d", $time, exp_s.vre, got.vre);
        if (got.vim != exp_s.vim)
          $display("%0t: value_im expected %0d actual %0d", $time, exp_s.vim, got.vim);
        if (got.g1r != exp_s.g1r)
          $display("%0t: grad_one_re expected %0d actual %0d", $time, exp_s.g1r, got.g1r);
        if (got.g1i != exp_s.g1i)
          $display("%0t: grad_one_im expected %0d actual %0d", $time, exp_s.g1i, got.g1i);
        if (got.g2r != exp_s.g2r)
          $display("%0t: grad_two_re expected %0d actual %0d", $time, exp_s.g2r, got.g2r);
        if (got.g2i != exp_s.g2i)
          $display("%0t: grad_two_im expected %0d actual %0d", $time, exp_s.g2i, got.g2i);
        if (got != exp_s) n_errors++;
      end
    end
  end

  initial begin
    n_errors = 0;
    hold_off_req = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_backpressure();
    test_random(350);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/wfvg_pkg.sv
hdl/wfvg_window.sv
hdl/wfvg_cordic.sv
hdl/windowed_fourier_value_and_gradient_core.sv
hdl/wfvg_checker.sv
dv/tb_windowed_fourier_value_and_gradient_core.sv
